@@ sv/ssc_pkg.sv @@
package ssc_pkg;

    // Field widths
    localparam int COORD_BITS = 16;
    localparam int WIDE_BITS  = COORD_BITS + 2;
    localparam int FRAME_BITS = 13;
    localparam int PIX_BITS   = 12;
    localparam int COLOR_BITS = 32;
    localparam int CMD_BITS   = 2;
    localparam int CFG_BITS   = 1;

    // Frame size limits and reset values
    localparam logic [FRAME_BITS-1:0] FRAME_MAX   = 13'd4096;
    localparam logic [FRAME_BITS-1:0] WIDTH_RST   = 13'd640;
    localparam logic [FRAME_BITS-1:0] HEIGHT_RST  = 13'd480;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_SPAN        = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_FLUSH       = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_DIRTY_BEGIN = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_DIRTY_END   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_BITS-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_BITS-1:0] CFG_FRAME_HEIGHT = 1'd1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [FRAME_BITS-1:0]        frame_t;
    typedef logic [PIX_BITS-1:0]          pix_t;
    typedef logic [COLOR_BITS-1:0]        color_t;
    typedef logic [CMD_BITS-1:0]          cmd_t;
    typedef logic [CFG_BITS-1:0]          cfg_idx_t;

    // Clipped view of the pending span
    typedef struct packed {
        logic keep;
        pix_t row;
        pix_t xs;
        pix_t xe;
    } clip_t;

endpackage

@@ sv/ssc_if.sv @@
interface ssc_in_if;
    logic               valid;
    logic               ready;
    ssc_pkg::cmd_t      cmd;
    ssc_pkg::coord_t    span_row;
    ssc_pkg::coord_t    span_start;
    ssc_pkg::coord_t    span_end;
    ssc_pkg::color_t    span_color;

    modport source (output valid, cmd, span_row, span_start, span_end, span_color,
                    input ready);
    modport sink   (input valid, cmd, span_row, span_start, span_end, span_color,
                    output ready);
endinterface

interface ssc_out_if;
    logic               valid;
    logic               ready;
    logic               emit_valid;
    ssc_pkg::pix_t      emit_row;
    ssc_pkg::pix_t      emit_start;
    ssc_pkg::pix_t      emit_end;
    ssc_pkg::color_t    emit_color;
    logic               box_active;
    ssc_pkg::frame_t    box_left;
    ssc_pkg::frame_t    box_top;
    ssc_pkg::pix_t      box_right;
    ssc_pkg::pix_t      box_bottom;

    modport source (output valid, emit_valid, emit_row, emit_start, emit_end, emit_color,
                    box_active, box_left, box_top, box_right, box_bottom,
                    input ready);
    modport sink   (input valid, emit_valid, emit_row, emit_start, emit_end, emit_color,
                    box_active, box_left, box_top, box_right, box_bottom,
                    output ready);
endinterface

interface ssc_cfg_if;
    logic                valid;
    logic                ready;
    ssc_pkg::cfg_idx_t   index;
    ssc_pkg::frame_t     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/ssc_clip.sv @@
module ssc_clip (
    input  ssc_pkg::coord_t pend_row,
    input  ssc_pkg::coord_t pend_start,
    input  ssc_pkg::coord_t pend_end,
    input  ssc_pkg::frame_t frame_w,
    input  ssc_pkg::frame_t frame_h,
    output ssc_pkg::clip_t  clip
);

    logic signed [ssc_pkg::WIDE_BITS-1:0] row_w;
    logic signed [ssc_pkg::WIDE_BITS-1:0] start_w;
    logic signed [ssc_pkg::WIDE_BITS-1:0] end_w;
    logic signed [ssc_pkg::WIDE_BITS-1:0] w_w;
    logic signed [ssc_pkg::WIDE_BITS-1:0] h_w;
    logic signed [ssc_pkg::WIDE_BITS-1:0] xs;
    logic signed [ssc_pkg::WIDE_BITS-1:0] xe;
    logic                                 row_ok;

    // sign-extend coordinates, zero-extend frame size
    assign row_w   = ssc_pkg::WIDE_BITS'(pend_row);
    assign start_w = ssc_pkg::WIDE_BITS'(pend_start);
    assign end_w   = ssc_pkg::WIDE_BITS'(pend_end);
    assign w_w     = $signed({{(ssc_pkg::WIDE_BITS-ssc_pkg::FRAME_BITS){1'b0}}, frame_w});
    assign h_w     = $signed({{(ssc_pkg::WIDE_BITS-ssc_pkg::FRAME_BITS){1'b0}}, frame_h});

    // clip row and columns to the frame
    assign row_ok = (row_w >= 0) && (row_w < h_w);
    assign xs     = (start_w < 0) ? '0 : start_w;
    assign xe     = (end_w >= w_w) ? (w_w - ssc_pkg::WIDE_BITS'(1)) : end_w;

    assign clip.keep = row_ok && (xs <= xe);
    assign clip.row  = row_w[ssc_pkg::PIX_BITS-1:0];
    assign clip.xs   = xs[ssc_pkg::PIX_BITS-1:0];
    assign clip.xe   = xe[ssc_pkg::PIX_BITS-1:0];

endmodule

@@ sv/sorted_span_coalescer.sv @@
// Sorted span coalescer.
// span_in carries one command per beat: span, flush, dirty begin or dirty end.
// Spans arrive sorted by row, start and color; touching spans of the same row
// and color are merged into one pending span, which is emitted (clipped to the
// frame) when a non-mergeable span or a flush arrives.
// result_out returns exactly one beat per input beat: emit_valid with the
// clipped span (zeros when nothing is emitted) plus the dirty box after it.
// cfg writes frame_width (index 0) and frame_height (index 1); values above
// 4096 act as 4096. Write it only while the block is idle.
// Each accepted input beat's result beat appears in the cycle after it is accepted.
// Throughput: one beat per cycle while result_out is ready; the merge, clip and box
// update all sit in one combinational stage in front of the registers.
// When the receiver stalls, the held result waits in the result register and
// span_in.ready drops until it is taken; no beat is lost.
// Reset empties the pending span and the result register, turns tracking off,
// clears the box and sets the frame to 640 x 480.
module sorted_span_coalescer (
    input  logic     clk,
    input  logic     rst_n,
    ssc_in_if.sink   span_in,
    ssc_out_if.source result_out,
    ssc_cfg_if.sink  cfg
);

    // configuration
    ssc_pkg::frame_t frame_w_reg;
    ssc_pkg::frame_t frame_h_reg;
    ssc_pkg::frame_t cfg_val;

    // pending span and dirty box state
    logic            pend_valid_reg, pend_valid_next;
    ssc_pkg::coord_t pend_row_reg,   pend_row_next;
    ssc_pkg::coord_t pend_start_reg, pend_start_next;
    ssc_pkg::coord_t pend_end_reg,   pend_end_next;
    ssc_pkg::color_t pend_color_reg, pend_color_next;
    logic            track_reg,      track_next;
    ssc_pkg::frame_t min_x_reg,      min_x_next;
    ssc_pkg::frame_t min_y_reg,      min_y_next;
    ssc_pkg::pix_t   max_x_reg,      max_x_next;
    ssc_pkg::pix_t   max_y_reg,      max_y_next;

    // result register
    logic            res_valid_reg;
    logic            emit_valid_reg;
    ssc_pkg::pix_t   emit_row_reg;
    ssc_pkg::pix_t   emit_start_reg;
    ssc_pkg::pix_t   emit_end_reg;
    ssc_pkg::color_t emit_color_reg;

    ssc_pkg::clip_t  clip;
    logic            accept;
    logic            span_ok;
    logic            merge;
    logic            do_emit;
    logic            emit_keep;
    logic signed [ssc_pkg::COORD_BITS:0] pend_end_inc;

    // configuration write, clamped to the frame limit
    assign cfg.ready = 1'b1;
    assign cfg_val   = (cfg.data > ssc_pkg::FRAME_MAX) ? ssc_pkg::FRAME_MAX : cfg.data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg <= ssc_pkg::WIDTH_RST;
            frame_h_reg <= ssc_pkg::HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ssc_pkg::CFG_FRAME_WIDTH:  frame_w_reg <= cfg_val;
                ssc_pkg::CFG_FRAME_HEIGHT: frame_h_reg <= cfg_val;
                default: ;
            endcase
        end
    end

    // clip the pending span against the frame
    ssc_clip u_clip (
        .pend_row   (pend_row_reg),
        .pend_start (pend_start_reg),
        .pend_end   (pend_end_reg),
        .frame_w    (frame_w_reg),
        .frame_h    (frame_h_reg),
        .clip       (clip)
    );

    // handshake: take a beat whenever the result slot is free or draining
    assign span_in.ready = !res_valid_reg || result_out.ready;
    assign accept        = span_in.valid && span_in.ready;

    // merge decision
    assign pend_end_inc = (ssc_pkg::COORD_BITS+1)'(pend_end_reg)
                          + (ssc_pkg::COORD_BITS+1)'(2'sd1);
    assign span_ok      = span_in.span_start <= span_in.span_end;
    assign merge        = pend_valid_reg
                          && (span_in.span_row == pend_row_reg)
                          && (span_in.span_color == pend_color_reg)
                          && ((ssc_pkg::COORD_BITS+1)'(span_in.span_start) <= pend_end_inc);
    assign do_emit      = pend_valid_reg
                          && (((span_in.cmd == ssc_pkg::CMD_SPAN) && span_ok && !merge)
                              || (span_in.cmd == ssc_pkg::CMD_FLUSH));
    assign emit_keep    = do_emit && clip.keep;

    // next state
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        pend_color_next = pend_color_reg;
        track_next      = track_reg;
        min_x_next      = min_x_reg;
        min_y_next      = min_y_reg;
        max_x_next      = max_x_reg;
        max_y_next      = max_y_reg;

        // widen the box with a kept span
        if (emit_keep && track_reg)
        begin
            if ({1'b0, clip.xs} < min_x_reg)
                min_x_next = {1'b0, clip.xs};
            if ({1'b0, clip.row} < min_y_reg)
                min_y_next = {1'b0, clip.row};
            if (clip.xe > max_x_reg)
                max_x_next = clip.xe;
            if (clip.row > max_y_reg)
                max_y_next = clip.row;
        end

        unique case (span_in.cmd)
            ssc_pkg::CMD_SPAN:
            begin
                if (span_ok)
                begin
                    if (merge)
                    begin
                        if (span_in.span_end > pend_end_reg)
                            pend_end_next = span_in.span_end;
                    end
                    else
                    begin
                        pend_valid_next = 1'b1;
                        pend_row_next   = span_in.span_row;
                        pend_start_next = span_in.span_start;
                        pend_end_next   = span_in.span_end;
                        pend_color_next = span_in.span_color;
                    end
                end
            end
            ssc_pkg::CMD_FLUSH:
            begin
                pend_valid_next = 1'b0;
            end
            ssc_pkg::CMD_DIRTY_BEGIN:
            begin
                min_x_next = frame_w_reg;
                min_y_next = frame_h_reg;
                max_x_next = '0;
                max_y_next = '0;
                track_next = 1'b1;
            end
            ssc_pkg::CMD_DIRTY_END:
            begin
                track_next = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_row_reg   <= '0;
            pend_start_reg <= '0;
            pend_end_reg   <= '0;
            pend_color_reg <= '0;
            track_reg      <= 1'b0;
            min_x_reg      <= '0;
            min_y_reg      <= '0;
            max_x_reg      <= '0;
            max_y_reg      <= '0;
        end
        else if (accept)
        begin
            pend_valid_reg <= pend_valid_next;
            pend_row_reg   <= pend_row_next;
            pend_start_reg <= pend_start_next;
            pend_end_reg   <= pend_end_next;
            pend_color_reg <= pend_color_next;
            track_reg      <= track_next;
            min_x_reg      <= min_x_next;
            min_y_reg      <= min_y_next;
            max_x_reg      <= max_x_next;
            max_y_reg      <= max_y_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (result_out.ready)
            res_valid_reg <= 1'b0;
    end

    // result payload; emit fields are zero when nothing is emitted
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            emit_valid_reg <= emit_keep;
            emit_row_reg   <= emit_keep ? clip.row       : '0;
            emit_start_reg <= emit_keep ? clip.xs        : '0;
            emit_end_reg   <= emit_keep ? clip.xe        : '0;
            emit_color_reg <= emit_keep ? pend_color_reg : '0;
        end
    end

    assign result_out.valid      = res_valid_reg;
    assign result_out.emit_valid = emit_valid_reg;
    assign result_out.emit_row   = emit_row_reg;
    assign result_out.emit_start = emit_start_reg;
    assign result_out.emit_end   = emit_end_reg;
    assign result_out.emit_color = emit_color_reg;
    assign result_out.box_active = track_reg;
    assign result_out.box_left   = min_x_reg;
    assign result_out.box_top    = min_y_reg;
    assign result_out.box_right  = max_x_reg;
    assign result_out.box_bottom = max_y_reg;

endmodule
